// ===== rtl/xcaf_pkg.sv =====
package xcaf_pkg;

    // One result item as it travels from the core to the output stage
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
    } t_result;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Request kinds (carried on tuser)
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // E8 or E9 opcode: top seven bits of the byte
    localparam logic [6:0]  OPCODE_E8_HI   = 7'h74;
    localparam logic [7:0]  EMPTY_ALL      = 8'hFF;
    localparam logic [31:0] SKIP_RESET     = 32'd5;
    localparam logic [31:0] SKIP_GAP       = 32'd4;
    localparam logic [31:0] OPERAND_BIAS   = 32'h0100_0000;
    localparam logic [31:0] OPERAND_UNBIAS = 32'hFF00_0000;

endpackage

// ===== rtl/xcaf_xform.sv =====
module xcaf_xform (
    input  logic        i_dir,
    input  logic [24:0] i_operand,
    input  logic [24:0] i_pos,
    output logic [24:0] o_operand
);
    import xcaf_pkg::*;

    logic [24:0] enc_sum;
    logic [24:0] dec_swap;

    // encode: add position, then byte swap with 7-bit offset
    assign enc_sum  = i_operand + i_pos;
    // decode: inverse swap, then subtract position
    assign dec_swap = {i_operand[7:0], i_operand[15:8], i_operand[23:16], i_operand[24]};

    always_comb begin
        if (i_dir == DIR_ENCODE) begin
            o_operand = {enc_sum[0], enc_sum[8:1], enc_sum[16:9], enc_sum[24:17]};
        end else begin
            o_operand = dec_swap - i_pos;
        end
    end

endmodule

// ===== rtl/xcaf_core.sv =====
module xcaf_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_dir,
    input  logic              i_acc,
    input  logic              i_cmd,
    input  logic [7:0]        i_data,
    input  logic              i_slot_free,
    output logic              o_busy,
    output logic              o_load,
    output xcaf_pkg::t_result o_res
);
    import xcaf_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_window, n_window;
    logic [7:0]  r_empty, n_empty;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_skip, n_skip;
    logic        r_dir, n_dir;

    logic [31:0] lo, hi, biased, hi_new;
    logic        hit, in_range;
    logic [24:0] new_operand;
    logic [63:0] win_mod;
    logic [2:0]  old_idx;
    logic [63:0] win_shift;
    logic [7:0]  drain_marks;
    logic        drain_last;
    logic        all_empty;
    logic        drain_go;

    assign lo       = r_window[31:0];
    assign hi       = r_window[63:32];
    assign hit      = (r_pos >= r_skip) && (lo[31:25] == OPCODE_E8_HI);
    assign biased   = hi + OPERAND_BIAS;
    assign in_range = (biased[31:25] == 7'd0);

    xcaf_xform u_xform (
        .i_dir     (r_dir),
        .i_operand (biased[24:0]),
        .i_pos     (r_pos[24:0]),
        .o_operand (new_operand)
    );

    assign hi_new  = {7'd0, new_operand} + OPERAND_UNBIAS;
    assign win_mod = (hit && in_range) ? {hi_new, lo} : r_window;

    // oldest occupied slot: lowest byte index whose empty mark is clear
    always_comb begin
        old_idx = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (!r_empty[7 - j]) begin
                old_idx = 3'(j);
            end
        end
    end

    assign win_shift   = r_window >> {old_idx, 3'b000};
    assign drain_marks = r_empty | (8'h80 >> old_idx);
    assign drain_last  = (drain_marks == EMPTY_ALL);
    assign all_empty   = (r_empty == EMPTY_ALL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_window <= '0;
            r_empty  <= EMPTY_ALL;
            r_pos    <= '0;
            r_skip   <= SKIP_RESET;
            r_dir    <= DIR_ENCODE;
        end else begin
            r_state  <= n_state;
            r_window <= n_window;
            r_empty  <= n_empty;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_dir    <= n_dir;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_window = r_window;
        n_empty  = r_empty;
        n_pos    = r_pos;
        n_skip   = r_skip;
        n_dir    = i_cfg_we ? i_cfg_dir : r_dir;
        o_load   = 1'b0;
        o_res    = '0;
        drain_go = 1'b0;

        unique case (r_state)
            ST_RUN: begin
                if (i_acc && (i_cmd == CMD_DATA)) begin
                    o_load   = 1'b1;
                    if (!r_empty[7]) begin
                        o_res = '{out_byte: r_window[7:0], has_byte: 1'b1, last: 1'b0};
                    end
                    n_window = {i_data, win_mod[63:8]};
                    n_empty  = {r_empty[6:0], 1'b0};
                    n_pos    = r_pos + 32'd1;
                    if (hit) begin
                        n_skip = r_pos + SKIP_GAP;
                    end
                end else if (i_acc && (i_cmd == CMD_FLUSH)) begin
                    drain_go = 1'b1;
                end
            end
            ST_DRAIN: begin
                drain_go = i_slot_free;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        if (drain_go) begin
            o_load = 1'b1;
            if (all_empty) begin
                o_res = '{out_byte: 8'd0, has_byte: 1'b0, last: 1'b1};
            end else begin
                o_res   = '{out_byte: win_shift[7:0], has_byte: 1'b1, last: drain_last};
                n_empty = drain_marks;
                n_state = ST_DRAIN;
            end
            if (all_empty || drain_last) begin
                n_state  = ST_RUN;
                n_window = '0;
                n_empty  = EMPTY_ALL;
                n_pos    = '0;
                n_skip   = SKIP_RESET;
                n_dir    = DIR_ENCODE;
            end
        end
    end

    assign o_busy = (r_state == ST_DRAIN);

endmodule

// ===== rtl/xcaf_out_reg.sv =====
module xcaf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  xcaf_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output xcaf_pkg::t_result o_res,
    output logic              o_slot_free
);
    import xcaf_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/x86_call_address_filter_top.sv =====
// E8/E9 branch filter for x86 code, one stream byte per request.
// Slave stream: tdata = data byte, tuser = command (0 data, 1 flush).
// Master stream: tdata = filtered byte, tuser = has_byte, tlast = end of flush.
// Config: i_cfg_we writes i_cfg_wdata into the direction bit
// (0 encode, 1 decode); write only while the block is idle.
// A data request yields exactly one result, registered in the cycle after
// acceptance; throughput is one request per cycle while tready is high, set by
// the single window/operand update between the state registers and the output
// register. A flush request yields one result per buffered byte (1 to 8),
// oldest first, the first registered likewise and then one per cycle while the
// receiver takes them; slave tready is low for the drain. With nothing buffered
// it yields one empty result marked tlast. After the last flush result all
// state, the direction bit included, returns to reset values.
// Reset (synchronous, active low) empties the window, clears position and
// sets the skip mark to five. When the receiver stalls, the output register
// holds its result and the slave side stops accepting once it is full.
module x86_call_address_filter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] i_s_axis_tuser,   // [0] cmd
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [0:0] o_m_axis_tuser,   // [0] has_byte
    output logic       o_m_axis_tlast
);
    import xcaf_pkg::*;

    logic    w_busy;
    logic    w_load;
    logic    w_slot_free;
    logic    w_acc;
    t_result w_core_res;
    t_result w_out_res;

    // accept when not draining and the output register can take a result
    assign o_s_axis_tready = !w_busy && w_slot_free;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    xcaf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_dir   (i_cfg_wdata),
        .i_acc       (w_acc),
        .i_cmd       (i_s_axis_tuser[0]),
        .i_data      (i_s_axis_tdata),
        .i_slot_free (w_slot_free),
        .o_busy      (w_busy),
        .o_load      (w_load),
        .o_res       (w_core_res)
    );

    xcaf_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_res       (w_core_res),
        .i_ready     (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_res       (w_out_res),
        .o_slot_free (w_slot_free)
    );

    assign o_m_axis_tdata    = w_out_res.out_byte;
    assign o_m_axis_tuser[0] = w_out_res.has_byte;
    assign o_m_axis_tlast    = w_out_res.last;

    // an empty result always carries a zero byte
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 8'd0))
        else $error("empty result with nonzero byte");

    // every accepted request shows a result in the next cycle
    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_m_axis_tvalid)
        else $error("accepted request produced no result");

    // no new request is taken while a flush drains
    a_drain_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_s_axis_tready)
        else $error("request accepted during flush drain");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import xcaf_pkg::*;

    // Opcodes and operand top bytes that make a rewritable call/jump
    localparam logic [7:0]  OP_CALL      = 8'hE8;
    localparam logic [7:0]  OP_JMP       = 8'hE9;
    localparam logic [7:0]  TOP_FWD      = 8'h00;   // small forward displacement
    localparam logic [7:0]  TOP_BACK     = 8'hFF;   // small backward displacement
    localparam logic [31:0] OPERAND_ROOM = 32'h0200_0000;
    localparam logic [31:0] OPERAND_MASK = 32'h01FF_FFFF;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PRINT_CAP    = 20;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_wdata;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;    // [7:0] data_byte
    logic [0:0] i_s_axis_tuser;    // [0] cmd
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;    // [7:0] out_byte
    logic [0:0] o_m_axis_tuser;    // [0] has_byte
    logic       o_m_axis_tlast;

    x86_call_address_filter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Shadow copy of the filter state, updated on every accepted request
    logic [63:0] shadow_win;      // byte 0 oldest, byte 7 newest
    logic [7:0]  shadow_empty;    // bit 7-j set: window byte j empty
    logic [31:0] shadow_pos;
    logic [31:0] shadow_skip;
    logic        shadow_dir;

    // Bytes predicted to leave the window, oldest first
    t_result     window_exits[$];

    int unsigned mismatch_count;
    int unsigned cycle_count;

    // Sender and receiver shaping knobs, set by the tests
    bit          tx_gaps;
    int unsigned burst_left;
    t_rx_mode    rx_mode;
    int unsigned hold_left;       // long receiver hold-off, counted down below
    logic [7:0]  rx_tick;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void shadow_reset();
        shadow_win   = '0;
        shadow_empty = EMPTY_ALL;
        shadow_pos   = '0;
        shadow_skip  = SKIP_RESET;
        shadow_dir   = DIR_ENCODE;
    endfunction

    // Encode side: 7-bit-offset byte shuffle of the displaced operand.
    // Note the last term overlaps the one before it; that is intended.
    function automatic logic [31:0] call_swap(input logic [31:0] v);
        logic [31:0] t;
        t = v << 7;
        return {24'd0, t[31:24]} | {16'd0, t[23:16], 8'd0} | {8'd0, t[15:8], 16'd0}
             | ({24'd0, t[7:0]} << 17);
    endfunction

    function automatic logic [31:0] call_unswap(input logic [31:0] v);
        logic [31:0] t;
        t = ({24'd0, v[31:24]} << 7) | {16'd0, v[23:16], 8'd0} | {8'd0, v[15:8], 16'd0}
          | {v[7:0], 24'd0};
        return t >> 7;
    endfunction

    function automatic void filter_request(input logic cmd, input logic [7:0] data);
        logic [31:0] lo;
        logic [31:0] x;
        logic        oldest_empty;
        t_result     r;
        bit          any;
        int          j;
        if (cmd == CMD_DATA) begin
            lo           = shadow_win[31:0];
            oldest_empty = shadow_empty[7];
            // E8/E9 just ahead of the newest four bytes, past the skip mark
            if (shadow_pos >= shadow_skip && lo[31:25] == OPCODE_E8_HI) begin
                x           = shadow_win[63:32] + OPERAND_BIAS;
                shadow_skip = shadow_pos + SKIP_GAP;
                if (x < OPERAND_ROOM) begin
                    if (shadow_dir == DIR_ENCODE) begin
                        x = call_swap((x + shadow_pos) & OPERAND_MASK);
                    end else begin
                        x = (call_unswap(x) - shadow_pos) & OPERAND_MASK;
                    end
                    shadow_win[63:32] = x + OPERAND_UNBIAS;
                end
            end
            r.out_byte = oldest_empty ? 8'h00 : shadow_win[7:0];
            r.has_byte = ~oldest_empty;
            r.last     = 1'b0;
            window_exits.push_back(r);
            shadow_win   = {data, shadow_win[63:8]};
            shadow_empty = shadow_empty << 1;
            shadow_pos   = shadow_pos + 32'd1;
        end else begin
            // Flush: buffered bytes oldest first, untouched
            any = 1'b0;
            for (j = 0; j < 8; j++) begin
                if (!shadow_empty[7 - j]) begin
                    r.out_byte = shadow_win[8 * j +: 8];
                    r.has_byte = 1'b1;
                    r.last     = 1'b0;
                    window_exits.push_back(r);
                    any = 1'b1;
                end
            end
            if (any) begin
                r = window_exits.pop_back();
                r.last = 1'b1;
            end else begin
                r.out_byte = 8'h00;
                r.has_byte = 1'b0;
                r.last     = 1'b1;
            end
            window_exits.push_back(r);
            shadow_reset();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking: results are compared first, then the config write and the
    // accepted request of the same edge update the shadow state. All reads
    // here see pre-edge values, as the block does.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            shadow_reset();
            window_exits.delete();
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (window_exits.size() == 0) begin
                    report_mismatch("unexpected result", o_m_axis_tdata, 8'h00);
                end else begin
                    want = window_exits.pop_front();
                    if (o_m_axis_tdata !== want.out_byte)
                        report_mismatch("out_byte", o_m_axis_tdata, want.out_byte);
                    if (o_m_axis_tuser[0] !== want.has_byte)
                        report_mismatch("has_byte", {7'd0, o_m_axis_tuser[0]},
                                        {7'd0, want.has_byte});
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch("last", {7'd0, o_m_axis_tlast}, {7'd0, want.last});
                end
            end
            if (i_cfg_we) begin
                shadow_dir = i_cfg_wdata;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                filter_request(i_s_axis_tuser[0], i_s_axis_tdata);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls on its own pattern, plus a long hold-off on demand
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 8'd1;
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_m_axis_tready <= 1'b1;
                RX_RANDOM:  i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: i_m_axis_tready <= (rx_tick[2:0] != 3'd3 && rx_tick[2:0] != 3'd6);
                default:    i_m_axis_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL x86_call_address_filter_top");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps when tx_gaps is set.
    // Returns at the edge where the request was accepted; valid stays high
    // so back-to-back requests go out without a bubble.
    // ------------------------------------------------------------------
    task automatic send_request(input logic cmd, input logic [7:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            if (tx_gaps) begin
                gap = $urandom_range(1, 6);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left = 64;
            end
        end
        burst_left--;
        i_s_axis_tvalid   <= 1'b1;
        i_s_axis_tdata    <= data;
        i_s_axis_tuser[0] <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering requests and wait until every predicted result is out
    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (window_exits.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Direction writes only once the block has nothing in flight
    task automatic write_direction(input logic dir);
        stop_sending();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dir;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Opcode, three operand bytes, then the top operand byte
    task automatic send_branch(input logic [7:0] opcode, input logic [7:0] top);
        int k;
        send_request(CMD_DATA, opcode);
        for (k = 0; k < 3; k++) send_request(CMD_DATA, 8'($urandom_range(0, 255)));
        send_request(CMD_DATA, top);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Flush with an empty window: one empty result marked last
    task automatic test_empty_flush();
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        send_request(CMD_FLUSH, 8'hFF);
        stop_sending();
    endtask

    // Encode a call with a forward operand, then a partial flush
    task automatic test_encode_call();
        write_direction(DIR_ENCODE);
        rx_mode = RX_PATTERN;
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, OP_CALL);
        send_request(CMD_DATA, 8'h78);
        send_request(CMD_DATA, 8'h56);
        send_request(CMD_DATA, 8'h34);
        send_request(CMD_DATA, TOP_FWD);
        send_request(CMD_DATA, 8'hFF);   // triggers the check, position 6
        send_request(CMD_FLUSH, 8'h00);
        stop_sending();
    endtask

    // Decode a jump with a backward operand; the flush also drops direction
    task automatic test_decode_call();
        write_direction(DIR_DECODE);
        tx_gaps = 1'b1;
        rx_mode = RX_RANDOM;
        send_request(CMD_DATA, 8'h00);
        send_request(CMD_DATA, OP_JMP);
        send_request(CMD_DATA, 8'h21);
        send_request(CMD_DATA, 8'h43);
        send_request(CMD_DATA, 8'h65);
        send_request(CMD_DATA, TOP_BACK);
        send_request(CMD_DATA, 8'h80);
        send_request(CMD_FLUSH, 8'h7F);
        send_request(CMD_DATA, OP_CALL); // encode again after the flush reset
        send_request(CMD_FLUSH, 8'h00);
        stop_sending();
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        int k;
        tx_gaps   = 1'b0;
        rx_mode   = RX_ALWAYS;
        hold_left = 80;
        for (k = 0; k < 8; k++) send_request(CMD_DATA, 8'($urandom_range(0, 255)));
        send_branch(OP_CALL, TOP_BACK);
        for (k = 0; k < 10; k++) send_request(CMD_DATA, 8'($urandom_range(0, 255)));
        send_request(CMD_FLUSH, 8'h00);
        stop_sending();
    endtask

    // Mostly branch sequences with random content, plus noise, broken
    // operands and flushes; direction and idling change between phases.
    task automatic test_random_stream(input int unsigned phases,
                                      input int unsigned per_phase);
        int unsigned p;
        int unsigned sent;
        int unsigned pick;
        logic [7:0]  op;
        logic [7:0]  top;
        for (p = 0; p < phases; p++) begin
            write_direction(logic'($urandom_range(0, 1)));
            tx_gaps = (p % 3 != 2);
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            sent = 0;
            while (sent < per_phase) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    send_request(CMD_FLUSH, 8'($urandom_range(0, 255)));
                    sent += 1;
                end else if (pick < 55) begin
                    op = ($urandom_range(0, 1) != 0) ? OP_JMP : OP_CALL;
                    case ($urandom_range(0, 4))
                        0, 1:    top = TOP_FWD;
                        2, 3:    top = TOP_BACK;
                        default: top = 8'($urandom_range(0, 255));   // broken operand
                    endcase
                    send_branch(op, top);
                    sent += 5;
                end else if (pick < 70) begin
                    send_request(CMD_DATA, ($urandom_range(0, 1) != 0) ? OP_JMP : OP_CALL);
                    sent += 1;
                end else begin
                    send_request(CMD_DATA, 8'($urandom_range(0, 255)));
                    sent += 1;
                end
            end
        end
        stop_sending();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= 1'b0;
        i_s_axis_tvalid   <= 1'b0;
        i_s_axis_tdata    <= 8'h00;
        i_s_axis_tuser[0] <= CMD_DATA;
        i_m_axis_tready   <= 1'b0;
        rx_tick           <= 8'h00;
        mismatch_count = 0;
        burst_left     = 0;
        tx_gaps        = 1'b0;
        rx_mode        = RX_ALWAYS;
        hold_left      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_flush();
        test_encode_call();
        test_decode_call();
        test_backpressure();
        test_random_stream(6, 30);

        // Anything further out of the block is a stray result
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS x86_call_address_filter_top");
        end else begin
            $display("FAIL x86_call_address_filter_top");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/xcaf_pkg.sv
rtl/xcaf_xform.sv
rtl/xcaf_core.sv
rtl/xcaf_out_reg.sv
rtl/x86_call_address_filter_top.sv
bench/tb_top.sv
